// File: rtl/swfb_pkg.sv
package swfb_pkg;

  localparam int SEQ_BITS       = 3;
  localparam int PAYLOAD_BITS   = 32;
  localparam int SEQ_SPACE      = 1 << SEQ_BITS;
  localparam int CMD_BITS       = 3;
  localparam int CFG_BITS       = 3;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_AW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [CMD_BITS-1:0]     cmd_t;

  localparam cmd_t CMD_STORE     = 3'd0;
  localparam cmd_t CMD_ACK       = 3'd1;
  localparam cmd_t CMD_SLIDE_CNT = 3'd2;
  localparam cmd_t CMD_SLIDE_WIN = 3'd3;
  localparam cmd_t CMD_SCAN      = 3'd4;

  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 3'd4;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_ACK,
    OP_SLIDE,
    OP_SCAN,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t      op;
    seq_t     seq;
    payload_t data;
    seq_t     amount;
  } job_t;

  typedef struct packed {
    logic     accepted;
    logic     in_window;
    logic     is_first;
    logic     is_last;
    seq_t     window_start;
    logic     out_valid;
    seq_t     out_seq;
    payload_t out_data;
    logic     last;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

// File: rtl/swfb_front.sv
module swfb_front (
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] seq_num, [34:3] frame_data, [37:35] slide_count
  input  logic [swfb_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // [2:0] cmd
  input  logic [swfb_pkg::CMD_BITS-1:0]       s_axis_tuser,
  input  swfb_pkg::seq_t                      window_size,
  output logic                                job_valid,
  input  logic                                job_ready,
  output swfb_pkg::job_t                      job
);
  import swfb_pkg::*;

  assign job_valid     = s_axis_tvalid;
  assign s_axis_tready = job_ready;

  // classify the command; both slides become one advance by an amount
  always_comb begin
    job.seq    = seq_t'(s_axis_tdata[2:0]);
    job.data   = payload_t'(s_axis_tdata[34:3]);
    job.amount = '0;
    unique case (s_axis_tuser)
      CMD_STORE: job.op = OP_STORE;
      CMD_ACK: job.op = OP_ACK;
      CMD_SLIDE_CNT: begin
        job.op     = OP_SLIDE;
        job.amount = seq_t'(s_axis_tdata[37:35]);
      end
      CMD_SLIDE_WIN: begin
        job.op     = OP_SLIDE;
        job.amount = window_size;
      end
      CMD_SCAN: job.op = OP_SCAN;
      default: job.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/swfb_queue.sv
module swfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  swfb_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output swfb_pkg::job_t pop_job
);
  import swfb_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// File: rtl/swfb_back.sv
module swfb_back (
  input  logic              clk,
  input  logic              rst,
  input  swfb_pkg::seq_t    window_size,
  input  logic              job_valid,
  output logic              job_ready,
  input  swfb_pkg::job_t    job,
  output logic              res_valid,
  input  logic              res_ready,
  output swfb_pkg::result_t result
);
  import swfb_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  seq_t                 start_seq;
  logic [SEQ_SPACE-1:0] pending;
  payload_t             payload [SEQ_SPACE];
  seq_t                 scan_k;
  seq_t                 scan_seq;
  logic [SEQ_SPACE-1:0] remaining;
  logic [SEQ_SPACE-1:0] rem_after;
  logic [SEQ_SPACE-1:0] scan_mask;
  seq_t                 scan_idx;
  logic                 out_free;
  logic                 take;
  logic                 emit;
  logic                 do_store;
  logic                 do_ack;
  logic                 do_slide;
  logic                 scan_load;
  logic                 scan_step;
  result_t              result_next;

  function automatic result_t window_fields(seq_t seq, seq_t start, seq_t ws);
    result_t r;
    seq_t    offs;
    seq_t    final_seq;
    r            = '0;
    offs         = seq - start;
    final_seq    = start + ws - seq_t'(1);
    r.in_window  = (offs < ws);
    r.is_first   = (seq == start);
    r.is_last    = (seq == final_seq);
    r.window_start = start;
    return r;
  endfunction

  assign out_free = !res_valid || res_ready;
  assign take     = job_valid && out_free;
  assign scan_idx = start_seq + scan_k;

  // pending slots inside the window, rotated so bit k is start_seq + k
  always_comb begin
    for (int k = 0; k < SEQ_SPACE; k++) begin
      scan_mask[k] = pending[seq_t'(start_seq + seq_t'(k))] && (seq_t'(k) < window_size);
    end
  end

  always_comb begin
    rem_after         = remaining;
    rem_after[scan_k] = 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take && job.op == OP_SCAN && scan_mask != '0) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (remaining[scan_k] && out_free && rem_after == '0) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready   = 1'b0;
    emit        = 1'b0;
    do_store    = 1'b0;
    do_ack      = 1'b0;
    do_slide    = 1'b0;
    scan_load   = 1'b0;
    scan_step   = 1'b0;
    result_next = '0;
    unique case (state)
      BK_IDLE: begin
        job_ready = out_free;
        if (take) begin
          if (job.op == OP_SLIDE) begin
            result_next = window_fields(job.seq, start_seq + job.amount, window_size);
          end else begin
            result_next = window_fields(job.seq, start_seq, window_size);
          end
          result_next.last = 1'b1;
          unique case (job.op)
            OP_STORE: begin
              emit     = 1'b1;
              do_store = result_next.in_window && !pending[job.seq];
              result_next.accepted = do_store;
            end
            OP_ACK: begin
              emit   = 1'b1;
              do_ack = 1'b1;
            end
            OP_SLIDE: begin
              emit     = 1'b1;
              do_slide = 1'b1;
            end
            OP_SCAN: begin
              // nothing pending: report one empty result
              if (scan_mask == '0) begin
                emit = 1'b1;
              end else begin
                scan_load = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        if (remaining[scan_k]) begin
          if (out_free) begin
            emit      = 1'b1;
            scan_step = 1'b1;
            result_next           = window_fields(scan_seq, start_seq, window_size);
            result_next.out_valid = 1'b1;
            result_next.out_seq   = scan_idx;
            result_next.out_data  = payload[scan_idx];
            result_next.last      = (rem_after == '0);
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      start_seq <= '0;
      pending   <= '0;
      res_valid <= 1'b0;
      remaining <= '0;
      scan_k    <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (do_store) begin
        pending[job.seq] <= 1'b1;
      end
      if (do_ack) begin
        pending[job.seq] <= 1'b0;
      end
      if (do_slide) begin
        start_seq <= start_seq + job.amount;
      end
      if (scan_load) begin
        remaining <= scan_mask;
        scan_k    <= '0;
      end else if (scan_step) begin
        remaining <= rem_after;
        scan_k    <= scan_k + seq_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
    if (scan_load) begin
      scan_seq <= job.seq;
    end
    if (do_store) begin
      payload[job.seq] <= job.data;
    end
  end

endmodule

// File: rtl/sliding_window_frame_buffer_core.sv
// A one-result item is held in the queue entry and then in the result register; a
// scan frame passes the queue entry, the scan registers and the result register.
// Store, acknowledge, slide and other commands each give one result when taken.
// A scan with nothing pending gives one empty result; else it blocks new commands
// and walks one slot per cycle, stalling at a pending slot while output is held.
// Reset (rst, synchronous): window start 0, all slots free, queue empty, size 4.
module sliding_window_frame_buffer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [swfb_pkg::CFG_BITS-1:0]        cfg_wr_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] seq_num, [34:3] frame_data, [37:35] slide_count, [39:38] zero
  input  logic [swfb_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // [2:0] cmd
  input  logic [swfb_pkg::CMD_BITS-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] accepted, [1] in_window, [2] is_first, [3] is_last, [6:4] window_start,
  // [9:7] out_seq, [41:10] out_data, [47:42] zero
  output logic [swfb_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // [0] out_valid
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import swfb_pkg::*;

  localparam int OUT_USED = 4 + 2 * SEQ_BITS + PAYLOAD_BITS;

  seq_t    window_size;
  job_t    front_job;
  job_t    back_job;
  logic    front_valid;
  logic    front_ready;
  logic    back_valid;
  logic    back_ready;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= seq_t'(WINDOW_SIZE_RESET);
    end else if (cfg_wr_en) begin
      window_size <= seq_t'(cfg_wr_data);
    end
  end

  swfb_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .window_size   (window_size),
    .job_valid     (front_valid),
    .job_ready     (front_ready),
    .job           (front_job)
  );

  swfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  swfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .job_valid   (back_valid),
    .job_ready   (back_ready),
    .job         (back_job),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .result      (result)
  );

  assign m_axis_tdata = {{(OUT_TDATA_BITS - OUT_USED){1'b0}},
                         result.out_data, result.out_seq, result.window_start,
                         result.is_last, result.is_first, result.in_window,
                         result.accepted};
  assign m_axis_tuser = result.out_valid;
  assign m_axis_tlast = result.last;

  // only a store can be accepted, and a scan result never is a store
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
    else $error("frame report flagged as accepted store");

  // every result that is not the final one of its item is a frame report
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-final result without a frame");

endmodule
